@@ src/imu_window_resampler_unit_macros.svh @@
// Assertion helpers for the resampler RTL.
// Each expects signals named clk and rst in the scope of use.
`ifndef IMU_WINDOW_RESAMPLER_UNIT_MACROS_SVH
`define IMU_WINDOW_RESAMPLER_UNIT_MACROS_SVH

// Same-cycle implication.
`define IWR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/iwr_pkg.sv @@
package iwr_pkg;

  localparam int NUM_AXES = 6;
  // The factor saturates at 2^SAT_BITS; the divider produces QBITS quotient bits.
  localparam int SAT_BITS = 40;
  localparam int QBITS = 42;
  localparam int DIV_STEPS = 2;
  localparam int SUM_W = SAT_BITS + 3;
  localparam int CFG_IDX_BITS = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW_START = 1'b0,
    REG_WINDOW_END   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_PASS  = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PASS,
    ST_CHECK,
    ST_INTERP,
    ST_EMIT,
    ST_UPDATE
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETUP,
    PH_MUL,
    PH_CHECK,
    PH_DIV,
    PH_ROUND,
    PH_ADD
  } phase_t;

  typedef struct packed {
    logic  capture;
    logic  start_interp;
    logic  at_end;
    logic  load_out;
    logic  out_from_interp;
    kind_t out_kind;
    logic  update_held;
  } cmd_t;

  typedef struct packed {
    logic in_first;
    logic held_before_start;
    logic held_before_end;
    logic new_at_end;
    logic interp_done;
    logic out_free;
  } status_t;

endpackage

@@ src/iwr_interp.sv @@
module iwr_interp #(
  parameter int TIME_BITS = 48,
  parameter int AXIS_BITS = 32
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  input  logic [TIME_BITS-1:0]                        at_time,
  input  logic [TIME_BITS-1:0]                        t0,
  input  logic [TIME_BITS-1:0]                        t1,
  input  logic [iwr_pkg::NUM_AXES-1:0][AXIS_BITS-1:0] held_vals,
  input  logic [iwr_pkg::NUM_AXES-1:0][AXIS_BITS-1:0] new_vals,
  output logic                                        done,
  output logic [iwr_pkg::NUM_AXES-1:0][AXIS_BITS-1:0] res_vals
);
  import iwr_pkg::*;

  localparam int CW = AXIS_BITS;
  localparam int NCH = (TIME_BITS + CW - 1) / CW;
  localparam int NW = NCH * CW;
  localparam int PW = AXIS_BITS + NW;
  localparam int HW = PW - QBITS;
  localparam int CMPW = (HW > TIME_BITS) ? HW : TIME_BITS;
  localparam int RW = TIME_BITS + 1;
  localparam int MCW = $clog2(NCH + 1);
  localparam int DIV_ITERS = QBITS / DIV_STEPS;
  localparam int DCW = $clog2(DIV_ITERS);
  localparam int AXW = $clog2(NUM_AXES);
  localparam logic [SAT_BITS:0] SAT_Q = {1'b1, {SAT_BITS{1'b0}}};
  localparam logic signed [SUM_W-1:0] AMAX_W =
    SUM_W'((64'sd1 <<< (AXIS_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] AMIN_W = ~AMAX_W;

  phase_t               phase;
  phase_t               phase_next;
  logic [AXW-1:0]       axis;
  logic [MCW-1:0]       mcnt;
  logic [DCW-1:0]       dcnt;
  logic [TIME_BITS-1:0] num;
  logic [TIME_BITS-1:0] den;
  logic                 tneg;
  logic [AXIS_BITS-1:0] mag;
  logic                 sgn;
  logic                 zero;
  logic [NW-1:0]        num_sh;
  logic [2*CW-1:0]      pp;
  logic [PW-1:0]        prod;
  logic [RW-1:0]        rem;
  logic [QBITS-1:0]     qsh;
  logic [SAT_BITS:0]    qres;

  // Time differences as magnitude and sign.
  logic [TIME_BITS-1:0] num_c;
  logic [TIME_BITS-1:0] den_c;
  logic                 nneg_c;
  logic                 dneg_c;

  always_comb begin
    nneg_c = at_time < t0;
    dneg_c = t1 < t0;
    num_c = nneg_c ? (t0 - at_time) : (at_time - t0);
    den_c = dneg_c ? (t0 - t1) : (t1 - t0);
  end

  // Per-axis difference of new and held value.
  logic [AXIS_BITS-1:0] a_cur;
  logic [AXIS_BITS-1:0] b_cur;
  logic [AXIS_BITS:0]   d_c;
  logic [AXIS_BITS:0]   dn_c;
  logic [AXIS_BITS-1:0] mag_c;

  always_comb begin
    a_cur = held_vals[axis];
    b_cur = new_vals[axis];
    d_c = {b_cur[AXIS_BITS-1], b_cur} - {a_cur[AXIS_BITS-1], a_cur};
    dn_c = ~d_c + 1'b1;
    mag_c = d_c[AXIS_BITS] ? dn_c[AXIS_BITS-1:0] : d_c[AXIS_BITS-1:0];
  end

  logic [CMPW-1:0] hi_ext;
  logic            too_big;

  always_comb begin
    hi_ext = CMPW'(prod[PW-1:QBITS]);
    too_big = hi_ext >= CMPW'(den);
  end

  // Restoring division, DIV_STEPS quotient bits per cycle.
  logic [RW-1:0]    rem_c;
  logic [QBITS-1:0] q_c;
  logic [RW-1:0]    trial;

  always_comb begin
    rem_c = rem;
    q_c = qsh;
    trial = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial = {rem_c[RW-2:0], q_c[QBITS-1]};
      q_c = {q_c[QBITS-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_c = trial - {1'b0, den};
        q_c[0] = 1'b1;
      end else begin
        rem_c = trial;
      end
    end
  end

  logic [QBITS:0]       q_rnd;
  logic [RW-1:0]        half_gap;

  always_comb begin
    half_gap = {1'b0, den} - rem;
    q_rnd = {1'b0, qsh} + (QBITS + 1)'(rem >= half_gap);
  end

  logic [SUM_W-1:0]     a_ext;
  logic [SUM_W-1:0]     q_ext;
  logic [SUM_W-1:0]     sum_c;
  logic [AXIS_BITS-1:0] clamp_c;

  always_comb begin
    a_ext = {{(SUM_W - AXIS_BITS){a_cur[AXIS_BITS-1]}}, a_cur};
    q_ext = SUM_W'(qres);
    sum_c = a_ext + (sgn ? (~q_ext + 1'b1) : q_ext);
    priority if ($signed(sum_c) > AMAX_W) begin
      clamp_c = AMAX_W[AXIS_BITS-1:0];
    end else if ($signed(sum_c) < AMIN_W) begin
      clamp_c = AMIN_W[AXIS_BITS-1:0];
    end else begin
      clamp_c = sum_c[AXIS_BITS-1:0];
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE:  if (start) phase_next = PH_SETUP;
      PH_SETUP: phase_next = PH_MUL;
      PH_MUL:   if (mcnt == MCW'(NCH)) phase_next = PH_CHECK;
      PH_CHECK: phase_next = (zero || too_big) ? PH_ADD : PH_DIV;
      PH_DIV:   if (dcnt == DCW'(DIV_ITERS - 1)) phase_next = PH_ROUND;
      PH_ROUND: phase_next = PH_ADD;
      PH_ADD:   phase_next = (axis == AXW'(NUM_AXES - 1)) ? PH_IDLE : PH_SETUP;
      default:  phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done <= 1'b0;
    end else begin
      phase <= phase_next;
      done <= (phase == PH_ADD) && (axis == AXW'(NUM_AXES - 1));
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase)
      PH_IDLE: begin
        if (start) begin
          num <= num_c;
          den <= den_c;
          tneg <= nneg_c ^ dneg_c;
          axis <= '0;
        end
      end
      PH_SETUP: begin
        mag <= mag_c;
        sgn <= d_c[AXIS_BITS] ^ tneg;
        zero <= (mag_c == '0) || (num == '0) || (den == '0);
        num_sh <= NW'(num);
        prod <= '0;
        mcnt <= '0;
      end
      PH_MUL: begin
        // Top chunk first; each registered partial product is accumulated in the cycle after the multiplier forms it.
        if (mcnt < MCW'(NCH)) begin
          pp <= mag * num_sh[NW-1 -: CW];
          num_sh <= num_sh << CW;
        end
        if (mcnt != '0) prod <= (prod << CW) + PW'(pp);
        mcnt <= mcnt + 1'b1;
      end
      PH_CHECK: begin
        if (zero) begin
          qres <= '0;
        end else if (too_big) begin
          qres <= SAT_Q;
        end else begin
          rem <= RW'(prod[PW-1:QBITS]);
          qsh <= prod[QBITS-1:0];
          dcnt <= '0;
        end
      end
      PH_DIV: begin
        rem <= rem_c;
        qsh <= q_c;
        dcnt <= dcnt + 1'b1;
      end
      PH_ROUND: begin
        if (q_rnd > {{(QBITS - SAT_BITS){1'b0}}, SAT_Q}) qres <= SAT_Q;
        else qres <= q_rnd[SAT_BITS:0];
      end
      PH_ADD: begin
        res_vals[axis] <= clamp_c;
        axis <= axis + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ src/iwr_dp.sv @@
module iwr_dp #(
  parameter int TIME_BITS = 48,
  parameter int AXIS_BITS = 32
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  iwr_pkg::cmd_t                               cmd,
  output iwr_pkg::status_t                            sts,
  input  logic [TIME_BITS-1:0]                        window_start,
  input  logic [TIME_BITS-1:0]                        window_end,
  input  logic                                        first_of_batch,
  input  logic [TIME_BITS-1:0]                        sample_time,
  input  logic [iwr_pkg::NUM_AXES-1:0][AXIS_BITS-1:0] in_vals,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [TIME_BITS-1:0]                        out_time,
  output logic [iwr_pkg::NUM_AXES-1:0][AXIS_BITS-1:0] out_vals,
  output iwr_pkg::kind_t                              out_kind,
  output logic                                        out_last
);
  import iwr_pkg::*;

  logic                                in_first;
  logic [TIME_BITS-1:0]                in_time;
  logic [NUM_AXES-1:0][AXIS_BITS-1:0]  new_vals;
  logic [TIME_BITS-1:0]                held_time;
  logic [NUM_AXES-1:0][AXIS_BITS-1:0]  held_vals;
  logic [TIME_BITS-1:0]                target;
  logic [TIME_BITS-1:0]                target_c;
  logic [NUM_AXES-1:0][AXIS_BITS-1:0]  res_vals;
  logic                                interp_done;

  assign target_c = cmd.at_end ? window_end : window_start;

  iwr_interp #(
    .TIME_BITS(TIME_BITS),
    .AXIS_BITS(AXIS_BITS)
  ) u_interp (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd.start_interp),
    .at_time    (target_c),
    .t0         (held_time),
    .t1         (in_time),
    .held_vals  (held_vals),
    .new_vals   (new_vals),
    .done       (interp_done),
    .res_vals   (res_vals)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_first <= first_of_batch;
      in_time <= sample_time;
      new_vals <= in_vals;
    end
    if (cmd.update_held) begin
      held_time <= in_time;
      held_vals <= new_vals;
    end
    if (cmd.start_interp) target <= target_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_time <= cmd.out_from_interp ? target : held_time;
      out_vals <= cmd.out_from_interp ? res_vals : held_vals;
      out_kind <= cmd.out_kind;
      out_last <= cmd.out_kind == KIND_END;
    end
  end

  always_comb begin
    sts.in_first = in_first;
    sts.held_before_start = held_time < window_start;
    sts.held_before_end = held_time < window_end;
    sts.new_at_end = in_time >= window_end;
    sts.interp_done = interp_done;
    sts.out_free = !out_valid || !out_stall;
  end

endmodule

@@ src/iwr_ctrl.sv @@
`include "imu_window_resampler_unit_macros.svh"

module iwr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  iwr_pkg::status_t sts,
  output iwr_pkg::cmd_t    cmd
);
  import iwr_pkg::*;

  state_t state;
  state_t state_next;
  logic   held_valid;
  logic   window_closed;
  logic   interp_end;
  logic   held_eff;
  logic   closed_eff;
  logic   end_straddle;

  // A batch start drops the held sample and reopens the window.
  assign held_eff = held_valid && !sts.in_first;
  assign closed_eff = window_closed && !sts.in_first;
  assign end_straddle = sts.held_before_end && sts.new_at_end;
  assign in_stall = state != ST_IDLE;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE: begin
        priority if (closed_eff) state_next = ST_IDLE;
        else if (!held_eff) state_next = ST_UPDATE;
        else if (sts.held_before_start) state_next = ST_INTERP;
        else if (sts.held_before_end) state_next = ST_PASS;
        else state_next = ST_UPDATE;
      end
      ST_PASS:   if (sts.out_free) state_next = ST_CHECK;
      ST_CHECK:  state_next = end_straddle ? ST_INTERP : ST_UPDATE;
      ST_INTERP: if (sts.interp_done) state_next = ST_EMIT;
      ST_EMIT:   if (sts.out_free) state_next = interp_end ? ST_UPDATE : ST_CHECK;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.out_kind = KIND_PASS;
    unique case (state)
      ST_IDLE:   cmd.capture = in_valid;
      ST_DECIDE: begin
        cmd.start_interp = !closed_eff && held_eff && sts.held_before_start;
        cmd.at_end = 1'b0;
      end
      ST_PASS:   cmd.load_out = sts.out_free;
      ST_CHECK:  begin
        cmd.start_interp = end_straddle;
        cmd.at_end = 1'b1;
      end
      ST_INTERP: ;
      ST_EMIT:   begin
        cmd.load_out = sts.out_free;
        cmd.out_from_interp = 1'b1;
        cmd.out_kind = interp_end ? KIND_END : KIND_START;
      end
      ST_UPDATE: cmd.update_held = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      held_valid <= 1'b0;
      window_closed <= 1'b0;
      interp_end <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.update_held) held_valid <= 1'b1;
      if (cmd.start_interp) interp_end <= cmd.at_end;
      if (state == ST_DECIDE && sts.in_first) begin
        window_closed <= 1'b0;
      end else if (state == ST_EMIT && sts.out_free && interp_end) begin
        window_closed <= 1'b1;
      end
    end
  end

  `IWR_ASSERT_NOW(a_load_needs_room, cmd.load_out, sts.out_free, "output word overwritten")
  `IWR_ASSERT_NEXT(a_end_closes, (state == ST_EMIT) && sts.out_free && interp_end, window_closed, "end word did not close window")
  `IWR_ASSERT_NEXT(a_update_holds, cmd.update_held, held_valid && (state == ST_IDLE), "held sample not taken")
  `IWR_ASSERT_NEXT(a_closed_drops, window_closed && (state == ST_DECIDE) && !sts.in_first, (state == ST_IDLE) && window_closed, "word not dropped while window closed")

endmodule

@@ src/imu_window_resampler_unit.sv @@
// A passed-through word is loaded into the output register from the PASS state, which waits
// while the output is stalled. Each interpolated word runs its 6 axes in turn through the
// shared multiply/divide unit (no division when the factor is zero or saturates). Words are
// dropped while the window is closed; a new word is accepted only in the idle state, and the
// next word is accepted while an output word waits. Reset (rst, synchronous) clears the
// window registers, the held sample and the closed flag, and empties the output.
module imu_window_resampler_unit #(
  parameter int TIME_BITS = 48,
  parameter int AXIS_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [iwr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [TIME_BITS-1:0]                 cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 first_of_batch,
  input  logic [TIME_BITS-1:0]                 sample_time,
  input  logic signed [AXIS_BITS-1:0]          rate_x,
  input  logic signed [AXIS_BITS-1:0]          rate_y,
  input  logic signed [AXIS_BITS-1:0]          rate_z,
  input  logic signed [AXIS_BITS-1:0]          accel_x,
  input  logic signed [AXIS_BITS-1:0]          accel_y,
  input  logic signed [AXIS_BITS-1:0]          accel_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [TIME_BITS-1:0]                 out_time,
  output logic signed [AXIS_BITS-1:0]          out_rate_x,
  output logic signed [AXIS_BITS-1:0]          out_rate_y,
  output logic signed [AXIS_BITS-1:0]          out_rate_z,
  output logic signed [AXIS_BITS-1:0]          out_accel_x,
  output logic signed [AXIS_BITS-1:0]          out_accel_y,
  output logic signed [AXIS_BITS-1:0]          out_accel_z,
  output logic [1:0]                           origin_kind,
  output logic                                 last_of_window
);
  import iwr_pkg::*;

  logic [TIME_BITS-1:0]               window_start;
  logic [TIME_BITS-1:0]               window_end;
  cmd_t                               cmd;
  status_t                            sts;
  logic [NUM_AXES-1:0][AXIS_BITS-1:0] in_vals;
  logic [NUM_AXES-1:0][AXIS_BITS-1:0] out_vals;
  kind_t                              out_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_end <= '0;
    end else if (cfg_write_en) begin
      if (cfg_index == REG_WINDOW_START) window_start <= cfg_data;
      if (cfg_index == REG_WINDOW_END) window_end <= cfg_data;
    end
  end

  assign in_vals = {accel_z, accel_y, accel_x, rate_z, rate_y, rate_x};

  iwr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  iwr_dp #(
    .TIME_BITS(TIME_BITS),
    .AXIS_BITS(AXIS_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .window_start  (window_start),
    .window_end    (window_end),
    .first_of_batch(first_of_batch),
    .sample_time   (sample_time),
    .in_vals       (in_vals),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_time      (out_time),
    .out_vals      (out_vals),
    .out_kind      (out_kind),
    .out_last      (last_of_window)
  );

  assign out_rate_x = out_vals[0];
  assign out_rate_y = out_vals[1];
  assign out_rate_z = out_vals[2];
  assign out_accel_x = out_vals[3];
  assign out_accel_y = out_vals[4];
  assign out_accel_z = out_vals[5];
  assign origin_kind = out_kind;

endmodule

@@ bench/imu_window_resampler_unit_test.sv @@
`timescale 1ns / 1ps

module imu_window_resampler_unit_test;
  import iwr_pkg::*;

  localparam int TIME_BITS = 48;
  localparam int AXIS_BITS = 32;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [AXIS_BITS-1:0] AXIS_MAX = {1'b0, {(AXIS_BITS-1){1'b1}}};
  localparam logic [AXIS_BITS-1:0] AXIS_MIN = {1'b1, {(AXIS_BITS-1){1'b0}}};
  localparam longint AXIS_HI = (longint'(1) <<< (AXIS_BITS - 1)) - 1;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_WORDS = 80;
  localparam int NUM_PHASES = 8;
  localparam int PRINT_CAP = 40;

  typedef logic [5:0][AXIS_BITS-1:0] axes_t;

  typedef struct packed {
    logic                 first;
    logic [TIME_BITS-1:0] t;
    axes_t                axes;
  } imu_sample_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] t;
    axes_t                axes;
    kind_t                kind;
    logic                 last;
  } imu_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  cfg_reg_t cfg_index = REG_WINDOW_START;
  logic [TIME_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic first_of_batch = 1'b0;
  logic [TIME_BITS-1:0] sample_time = '0;
  logic signed [AXIS_BITS-1:0] rate_x = '0;
  logic signed [AXIS_BITS-1:0] rate_y = '0;
  logic signed [AXIS_BITS-1:0] rate_z = '0;
  logic signed [AXIS_BITS-1:0] accel_x = '0;
  logic signed [AXIS_BITS-1:0] accel_y = '0;
  logic signed [AXIS_BITS-1:0] accel_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TIME_BITS-1:0] out_time;
  logic signed [AXIS_BITS-1:0] out_rate_x;
  logic signed [AXIS_BITS-1:0] out_rate_y;
  logic signed [AXIS_BITS-1:0] out_rate_z;
  logic signed [AXIS_BITS-1:0] out_accel_x;
  logic signed [AXIS_BITS-1:0] out_accel_y;
  logic signed [AXIS_BITS-1:0] out_accel_z;
  logic [1:0] origin_kind;
  logic last_of_window;

  imu_sample_t sample_q[$];
  imu_word_t resampled_q[$];
  imu_sample_t next_sample;

  // resampler shadow state
  logic held_valid = 1'b0;
  logic [TIME_BITS-1:0] held_time = '0;
  axes_t held_axes = '0;
  logic window_shut = 1'b0;
  logic [TIME_BITS-1:0] win_start = '0;
  logic [TIME_BITS-1:0] win_end = '0;

  bit word_sent = 1'b0;
  bit idle_on = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int pushed_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  int kind_count[3] = '{0, 0, 0};
  string axis_label[6] = '{"out_rate_x", "out_rate_y", "out_rate_z",
                           "out_accel_x", "out_accel_y", "out_accel_z"};

  imu_window_resampler_unit #(
    .TIME_BITS(TIME_BITS),
    .AXIS_BITS(AXIS_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .first_of_batch(first_of_batch),
    .sample_time   (sample_time),
    .rate_x        (rate_x),
    .rate_y        (rate_y),
    .rate_z        (rate_z),
    .accel_x       (accel_x),
    .accel_y       (accel_y),
    .accel_z       (accel_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_time      (out_time),
    .out_rate_x    (out_rate_x),
    .out_rate_y    (out_rate_y),
    .out_rate_z    (out_rate_z),
    .out_accel_x   (out_accel_x),
    .out_accel_y   (out_accel_y),
    .out_accel_z   (out_accel_z),
    .origin_kind   (origin_kind),
    .last_of_window(last_of_window)
  );

  always #5 clk = ~clk;

  task automatic flag_error(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < PRINT_CAP) begin
      $display("ERROR %0t ns: %s got %0h expected %0h", $time, what, got, want);
    end
    error_count++;
  endtask

  // a + round((b - a) * (tt - t0) / (t1 - t0)), factor clipped at 2^40, then saturated
  function automatic logic [AXIS_BITS-1:0] lerp_axis(logic signed [AXIS_BITS-1:0] a,
                                                     logic signed [AXIS_BITS-1:0] b,
                                                     logic [TIME_BITS-1:0] tt,
                                                     logic [TIME_BITS-1:0] t0,
                                                     logic [TIME_BITS-1:0] t1);
    longint d;
    longint v;
    longint q;
    logic [AXIS_BITS:0] mag;
    logic [TIME_BITS-1:0] num;
    logic [TIME_BITS-1:0] den;
    logic [127:0] prod;
    logic [127:0] quo;
    logic [127:0] rem;
    bit neg;
    d = longint'(b) - longint'(a);
    neg = (d < 0);
    mag = neg ? (AXIS_BITS + 1)'(-d) : (AXIS_BITS + 1)'(d);
    num = (tt >= t0) ? tt - t0 : t0 - tt;
    den = (t1 >= t0) ? t1 - t0 : t0 - t1;
    neg = neg ^ (tt < t0) ^ (t1 < t0);
    q = 0;
    if (den != 0 && mag != 0 && num != 0) begin
      prod = 128'(mag) * 128'(num);
      quo = prod / 128'(den);
      rem = prod % 128'(den);
      if (rem >= 128'(den) - rem) quo = quo + 1;
      if (quo > (128'(1) << 40)) quo = 128'(1) << 40;
      q = neg ? -longint'(quo[40:0]) : longint'(quo[40:0]);
    end
    v = longint'(a) + q;
    if (v > AXIS_HI) v = AXIS_HI;
    else if (v < -AXIS_HI - 1) v = -AXIS_HI - 1;
    return AXIS_BITS'(v);
  endfunction

  function automatic imu_word_t blend_at(logic [TIME_BITS-1:0] tt, imu_sample_t s, kind_t k);
    imu_word_t w;
    int j;
    w.t = tt;
    for (j = 0; j < 6; j++) begin
      w.axes[j] = lerp_axis(held_axes[j], s.axes[j], tt, held_time, s.t);
    end
    w.kind = k;
    w.last = (k == KIND_END);
    return w;
  endfunction

  // advance the shadow state by one accepted word and queue what it yields
  task automatic resample_word(imu_sample_t s);
    imu_word_t w;
    if (s.first) begin
      held_valid = 1'b0;
      window_shut = 1'b0;
    end
    if (!window_shut) begin
      if (held_valid) begin
        if (held_time < win_start) begin
          w = blend_at(win_start, s, KIND_START);
          resampled_q.insert(resampled_q.size(), w);
        end else if (held_time < win_end) begin
          w.t = held_time;
          w.axes = held_axes;
          w.kind = KIND_PASS;
          w.last = 1'b0;
          resampled_q.insert(resampled_q.size(), w);
        end
        if (held_time < win_end && s.t >= win_end) begin
          w = blend_at(win_end, s, KIND_END);
          resampled_q.insert(resampled_q.size(), w);
          window_shut = 1'b1;
        end
      end
      held_valid = 1'b1;
      held_time = s.t;
      held_axes = s.axes;
    end
  endtask

  task automatic check_word(imu_word_t got);
    imu_word_t want;
    int j;
    if (resampled_q.size() == 0) begin
      flag_error("resampled word with none pending, out_time", 64'(got.t), '0);
    end else begin
      want = resampled_q.pop_front();
      if (got.t !== want.t) flag_error("out_time", 64'(got.t), 64'(want.t));
      for (j = 0; j < 6; j++) begin
        if (got.axes[j] !== want.axes[j]) begin
          flag_error(axis_label[j], 64'(got.axes[j]), 64'(want.axes[j]));
        end
      end
      if (got.kind !== want.kind) flag_error("origin_kind", 64'(got.kind), 64'(want.kind));
      if (got.last !== want.last) flag_error("last_of_window", 64'(got.last), 64'(want.last));
      kind_count[int'(want.kind)]++;
      checked_count++;
    end
  endtask

  // driver: present the next word once the current one is taken
  always @(negedge clk) begin
    if (!in_valid || word_sent) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (sample_q.size() != 0) begin
        next_sample = sample_q.pop_front();
        first_of_batch <= next_sample.first;
        sample_time <= next_sample.t;
        rate_x <= next_sample.axes[0];
        rate_y <= next_sample.axes[1];
        rate_z <= next_sample.axes[2];
        accel_x <= next_sample.axes[3];
        accel_y <= next_sample.axes[4];
        accel_z <= next_sample.axes[5];
        in_valid <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output backpressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
    end
  end

  always @(posedge clk) begin : monitor
    imu_word_t got;
    imu_sample_t seen;
    bit word_out;
    word_sent = !rst && in_valid && !in_stall;
    word_out = !rst && out_valid && !out_stall;
    if (word_out) begin
      got.t = out_time;
      got.axes = {out_accel_z, out_accel_y, out_accel_x, out_rate_z, out_rate_y, out_rate_x};
      got.kind = kind_t'(origin_kind);
      got.last = last_of_window;
      check_word(got);
    end
    if (word_sent) begin
      seen.first = first_of_batch;
      seen.t = sample_time;
      seen.axes = {accel_z, accel_y, accel_x, rate_z, rate_y, rate_x};
      resample_word(seen);
      sent_count++;
    end
    quiet_cycles = (word_sent || word_out) ? 0 : quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Watchdog: no handshake for %0d cycles, %0d results still pending",
             QUIET_LIMIT, resampled_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [TIME_BITS-1:0] rand_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  function automatic axes_t rand_axes();
    axes_t v;
    int j;
    for (j = 0; j < 6; j++) begin
      case ($urandom_range(0, 7))
        0: v[j] = AXIS_MAX;
        1: v[j] = AXIS_MIN;
        2: v[j] = '0;
        3: v[j] = AXIS_BITS'($urandom_range(0, 2000)) - AXIS_BITS'(1000);
        default: v[j] = $urandom;
      endcase
    end
    return v;
  endfunction

  task automatic add_word(logic first, logic [TIME_BITS-1:0] t, axes_t axes);
    imu_sample_t s;
    s.first = first;
    s.t = t;
    s.axes = axes;
    sample_q.insert(sample_q.size(), s);
    pushed_count++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [TIME_BITS-1:0] value);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic set_window(logic [TIME_BITS-1:0] ws, logic [TIME_BITS-1:0] we);
    write_reg(REG_WINDOW_START, ws);
    win_start = ws;
    write_reg(REG_WINDOW_END, we);
    win_end = we;
  endtask

  // one batch sweeping across [lo, hi], with some noise and broken sequences
  task automatic add_batch(logic [TIME_BITS-1:0] lo, logic [TIME_BITS-1:0] hi);
    longint unsigned step;
    longint unsigned t;
    longint unsigned stop;
    int k;
    int n;
    int pick;
    step = (64'(hi) - 64'(lo) + 1) / 6 + 1;
    k = $urandom_range(0, 3);
    t = (64'(lo) > step * k) ? 64'(lo) - step * k : 0;
    stop = 64'(hi) + 2 * step;
    add_word(1'b1, TIME_BITS'(t), rand_axes());
    n = 1;
    while (n < 40 && t <= stop) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        t = (t > step) ? t - step : 0;
      end else if (pick > 3) begin
        t = t + (step * $urandom_range(0, 200)) / 100;
      end
      if (t > 64'(TIME_MAX)) t = 64'(TIME_MAX);
      if (pick == 1) add_word(1'($urandom), rand_time(), rand_axes());
      else add_word(pick == 2, TIME_BITS'(t), rand_axes());
      n++;
    end
  endtask

  task automatic drain_block();
    while (sent_count != pushed_count || resampled_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [TIME_BITS-1:0] ws;
    logic [TIME_BITS-1:0] we;
    int phase;
    int target;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    set_window(48'd1000, 48'd2000);
    add_word(1'b1, 48'd900, {6{AXIS_MAX}});
    // equal timestamps before the window: factor zero
    add_word(1'b0, 48'd900, {6{AXIS_MIN}});
    add_word(1'b0, 48'd1100, {AXIS_MIN, AXIS_MAX, 32'd12345, 32'hffffffff, 32'd1, 32'd0});
    add_word(1'b0, 48'd1500, {6{32'd0}});
    add_word(1'b0, 48'd2500, {6{AXIS_MIN}});
    // window now closed: drop
    add_word(1'b0, 48'd3000, {6{AXIS_MAX}});
    add_word(1'b1, 48'd0, {6{32'd0}});
    add_word(1'b0, TIME_MAX, {6{AXIS_MAX}});
    add_word(1'b1, 48'd10, {6{AXIS_MIN}});
    // steep extrapolation: factor saturates
    add_word(1'b0, 48'd11, {6{AXIS_MAX}});
    add_word(1'b0, 48'd5, {AXIS_MAX, AXIS_MIN, 32'd7, 32'hfffffff9, AXIS_MIN, AXIS_MAX});
    add_word(1'b0, 48'd1999, rand_axes());
    add_word(1'b0, 48'd2000, {6{AXIS_MIN}});
    add_word(1'b1, 48'd2000, {6{AXIS_MAX}});
    add_word(1'b0, 48'd2100, {6{32'd0}});
    add_word(1'b1, 48'd1500, {6{AXIS_MAX}});
    add_word(1'b0, 48'd1500, {6{AXIS_MIN}});
    add_word(1'b0, TIME_MAX, {AXIS_MIN, 32'd0, AXIS_MAX, 32'd3, AXIS_MIN, AXIS_MAX});
    drain_block();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: begin
          ws = '0;
          we = '0;
        end
        2: begin
          ws = TIME_MAX;
          we = TIME_MAX;
        end
        3: begin
          ws = 48'd9000 + 48'($urandom_range(0, 5000));
          we = ws - 48'($urandom_range(1, 3000));
        end
        4: begin
          we = TIME_MAX;
          ws = TIME_MAX - 48'($urandom_range(1, 2000));
        end
        5: begin
          ws = '0;
          we = 48'($urandom_range(1, 4000));
        end
        6: begin
          ws = rand_time() >> 2;
          we = ws + (rand_time() >> 2);
        end
        default: begin
          ws = rand_time() >> 8;
          we = ws + 48'($urandom_range(1, 5000));
        end
      endcase
      idle_on = (phase != NUM_PHASES - 1);
      set_window(ws, we);
      target = pushed_count + PHASE_WORDS;
      if (ws == TIME_MAX) begin
        // huge span over a one-microsecond pair: quotient overflows 64 bits
        add_word(1'b1, '0, {6{AXIS_MIN}});
        add_word(1'b0, 48'd1, {6{AXIS_MAX}});
      end
      while (pushed_count < target) add_batch(ws < we ? ws : we, ws < we ? we : ws);
      drain_block();
    end

    $display("Sent %0d IMU words over %0d window settings, checked %0d resampled words",
             sent_count, NUM_PHASES + 1, checked_count);
    $display("(%0d at window start, %0d passed through, %0d at window end), %0d mismatches",
             kind_count[0], kind_count[1], kind_count[2], error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
